FILE: sv/yrdf_pkg.sv
// Shared types, constants and helpers for the YOLO row decode and filter unit.
`timescale 1ns / 1ps

package yrdf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int BOX_SHIFT   = 2 * FRAC_BITS + 1;
    localparam int MAX_CLASSES = 80;

    // row positions
    localparam logic [10:0] POS_CX          = 11'd0;
    localparam logic [10:0] POS_CY          = 11'd1;
    localparam logic [10:0] POS_W           = 11'd2;
    localparam logic [10:0] POS_H           = 11'd3;
    localparam logic [10:0] POS_OBJ         = 11'd4;
    localparam logic [10:0] POS_FIRST_CLASS = 11'd5;
    localparam logic [10:0] POS_MAX         = 11'd2047;

    // configuration register indexes
    localparam logic [2:0] REG_CONF_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_NET_WIDTH      = 3'd1;
    localparam logic [2:0] REG_NET_HEIGHT     = 3'd2;
    localparam logic [2:0] REG_PAD_LEFT       = 3'd3;
    localparam logic [2:0] REG_PAD_TOP        = 3'd4;
    localparam logic [2:0] REG_INVERSE_SCALE  = 3'd5;
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd6;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd7;

    typedef struct packed {
        logic [16:0] centre_x;
        logic [16:0] centre_y;
        logic [16:0] raw_width;
        logic [16:0] raw_height;
        logic [16:0] objectness;
        logic [16:0] best_score;
        logic [9:0]  best_class;
        logic [15:0] row_number;
    } row_rec_t;

    typedef struct packed {
        logic [16:0] conf_threshold;
        logic [12:0] net_width;
        logic [12:0] net_height;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [23:0] inverse_scale;
        logic [13:0] frame_width;
        logic [13:0] frame_height;
    } cfg_t;

    // limit to at most lim, then to at least zero
    function automatic logic [45:0] clamp_edge(input logic signed [58:0] v,
                                               input logic signed [58:0] lim);
        logic signed [58:0] t;
        t = v;
        if (t > lim) t = lim;
        if (t < 59'sd0) t = '0;
        return t[45:0];
    endfunction

endpackage

FILE: sv/yrdf_front.sv
// Front end: takes row values, keeps box fields and best class, queues finished rows.
`timescale 1ns / 1ps

module yrdf_front
    import yrdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [16:0] s_value,
    input  logic        s_row_end,
    input  logic        q_full,
    output logic        q_push,
    output row_rec_t    q_push_rec
);

    logic [10:0] pos_reg, pos_next;
    logic [16:0] cx_reg, cx_next;
    logic [16:0] cy_reg, cy_next;
    logic [16:0] w_reg, w_next;
    logic [16:0] h_reg, h_next;
    logic [16:0] obj_reg, obj_next;
    logic [16:0] best_reg, best_next;
    logic [9:0]  class_reg, class_next;
    logic [15:0] row_reg, row_next;
    logic [16:0] best_upd;
    logic [9:0]  class_upd;
    logic [10:0] class_pos;
    logic        xfer;

    assign s_ready   = !q_full;
    assign xfer      = s_valid && s_ready;
    assign class_pos = pos_reg - POS_FIRST_CLASS;

    always_comb begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        obj_next  = obj_reg;
        best_upd  = best_reg;
        class_upd = class_reg;
        pos_next  = pos_reg;
        row_next  = row_reg;
        if (xfer) begin
            case (pos_reg)
                POS_CX:  cx_next  = s_value;
                POS_CY:  cy_next  = s_value;
                POS_W:   w_next   = s_value;
                POS_H:   h_next   = s_value;
                POS_OBJ: obj_next = s_value;
                default: begin
                    if (class_pos < 11'(MAX_CLASSES)) begin
                        if (class_pos == 11'd0 || s_value > best_reg) begin
                            best_upd  = s_value;
                            class_upd = class_pos[9:0];
                        end
                    end
                end
            endcase
            if (pos_reg != POS_MAX) pos_next = pos_reg + 11'd1;
        end
        best_next  = best_upd;
        class_next = class_upd;
        if (xfer && s_row_end) begin
            pos_next   = '0;
            cx_next    = '0;
            cy_next    = '0;
            w_next     = '0;
            h_next     = '0;
            obj_next   = '0;
            best_next  = '0;
            class_next = '0;
            row_next   = row_reg + 16'd1;
        end
    end

    assign q_push = xfer && s_row_end && (pos_reg >= POS_FIRST_CLASS);

    always_comb begin
        q_push_rec.centre_x   = cx_reg;
        q_push_rec.centre_y   = cy_reg;
        q_push_rec.raw_width  = w_reg;
        q_push_rec.raw_height = h_reg;
        q_push_rec.objectness = obj_reg;
        q_push_rec.best_score = best_upd;
        q_push_rec.best_class = class_upd;
        q_push_rec.row_number = row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            obj_reg   <= '0;
            best_reg  <= '0;
            class_reg <= '0;
            row_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            obj_reg   <= obj_next;
            best_reg  <= best_next;
            class_reg <= class_next;
            row_reg   <= row_next;
        end
    end

endmodule

FILE: sv/yrdf_queue.sv
// Short queue of finished row records between front and back.
`timescale 1ns / 1ps

module yrdf_queue
    import yrdf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  row_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output row_rec_t head_rec,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    row_rec_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/yrdf_back.sv
// Back end: confidence test, box decode, letterbox removal and result register.
`timescale 1ns / 1ps

module yrdf_back
    import yrdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_empty,
    input  row_rec_t    q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_class_id,
    output logic [16:0] m_confidence,
    output logic [12:0] m_box_left,
    output logic [12:0] m_box_top,
    output logic [12:0] m_box_width,
    output logic [12:0] m_box_height,
    output logic [15:0] m_row_number
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PROD  = 6'b000010,
        ST_DIFF  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_CLAMP = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   done, start, out_free;

    row_rec_t    rec_reg;
    logic [29:0] cnx_reg, snx_reg, cny_reg, sny_reg;
    logic [33:0] conf_prod_reg;
    logic [31:0] dx_mag_reg, dy_mag_reg;
    logic        dx_neg_reg, dy_neg_reg;
    logic [16:0] conf_reg;
    logic        pass_reg;
    logic [55:0] p0x_reg, p0y_reg;
    logic [53:0] p1x_reg, p1y_reg;
    logic [45:0] ax_reg, bx_reg, ay_reg, by_reg;

    logic [9:0]  m_class_reg;
    logic [16:0] m_conf_reg;
    logic [12:0] m_left_reg, m_top_reg, m_width_reg, m_height_reg;
    logic [15:0] m_row_reg;

    logic [32:0] dx, dy, dx_abs, dy_abs;
    logic [17:0] conf_raw, conf_sat;
    logic signed [58:0] ex, ey, x0, x1, y0, y1, lim_x, lim_y;
    logic [45:0] ext_x, ext_y;

    assign out_free = !m_valid_reg || m_ready;
    assign done     = (state_reg == ST_WRITE) && (!pass_reg || out_free);
    assign start    = !q_empty && ((state_reg == ST_IDLE) || done);
    assign q_pop    = start;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_PROD;
            ST_PROD:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_WRITE;
            ST_WRITE: begin
                if (done) state_next = start ? ST_PROD : ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (done && pass_reg) m_valid_next = 1'b1;
    end

    // signed offsets: 2*c*net - s*net - pad*2^(F+1)
    always_comb begin
        dx = {2'b00, cnx_reg, 1'b0} - {3'b000, snx_reg}
             - (33'(cfg.pad_left) << (FRAC_BITS + 1));
        dy = {2'b00, cny_reg, 1'b0} - {3'b000, sny_reg}
             - (33'(cfg.pad_top) << (FRAC_BITS + 1));
        dx_abs = dx[32] ? (33'd0 - dx) : dx;
        dy_abs = dy[32] ? (33'd0 - dy) : dy;
        conf_raw = conf_prod_reg[33:FRAC_BITS];
        conf_sat = (conf_raw > (18'd1 << FRAC_BITS)) ? (18'd1 << FRAC_BITS) : conf_raw;
    end

    always_comb begin
        ex    = {3'b000, p0x_reg};
        ey    = {3'b000, p0y_reg};
        x0    = dx_neg_reg ? -ex : ex;
        y0    = dy_neg_reg ? -ey : ey;
        x1    = x0 + $signed({4'b0000, p1x_reg, 1'b0});
        y1    = y0 + $signed({4'b0000, p1y_reg, 1'b0});
        lim_x = $signed(({45'd0, cfg.frame_width} - 59'd1) << BOX_SHIFT);
        lim_y = $signed(({45'd0, cfg.frame_height} - 59'd1) << BOX_SHIFT);
        ext_x = bx_reg - ax_reg;
        ext_y = by_reg - ay_reg;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) rec_reg <= q_head;
        if (state_reg == ST_PROD) begin
            cnx_reg       <= {13'd0, rec_reg.centre_x} * {17'd0, cfg.net_width};
            snx_reg       <= {13'd0, rec_reg.raw_width} * {17'd0, cfg.net_width};
            cny_reg       <= {13'd0, rec_reg.centre_y} * {17'd0, cfg.net_height};
            sny_reg       <= {13'd0, rec_reg.raw_height} * {17'd0, cfg.net_height};
            conf_prod_reg <= {17'd0, rec_reg.objectness} * {17'd0, rec_reg.best_score};
        end
        if (state_reg == ST_DIFF) begin
            dx_mag_reg <= dx_abs[31:0];
            dy_mag_reg <= dy_abs[31:0];
            dx_neg_reg <= dx[32];
            dy_neg_reg <= dy[32];
            conf_reg   <= conf_sat[16:0];
            pass_reg   <= (conf_sat >= {1'b0, cfg.conf_threshold});
        end
        if (state_reg == ST_MUL) begin
            p0x_reg <= {24'd0, dx_mag_reg} * {32'd0, cfg.inverse_scale};
            p0y_reg <= {24'd0, dy_mag_reg} * {32'd0, cfg.inverse_scale};
            p1x_reg <= {24'd0, snx_reg} * {30'd0, cfg.inverse_scale};
            p1y_reg <= {24'd0, sny_reg} * {30'd0, cfg.inverse_scale};
        end
        if (state_reg == ST_CLAMP) begin
            ax_reg <= clamp_edge(x0, lim_x);
            bx_reg <= clamp_edge(x1, lim_x);
            ay_reg <= clamp_edge(y0, lim_y);
            by_reg <= clamp_edge(y1, lim_y);
        end
        if (done && pass_reg) begin
            m_class_reg  <= rec_reg.best_class;
            m_conf_reg   <= conf_reg;
            m_left_reg   <= ax_reg[BOX_SHIFT +: 13];
            m_top_reg    <= ay_reg[BOX_SHIFT +: 13];
            m_width_reg  <= ext_x[BOX_SHIFT +: 13];
            m_height_reg <= ext_y[BOX_SHIFT +: 13];
            m_row_reg    <= rec_reg.row_number;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_class_id   = m_class_reg;
    assign m_confidence = m_conf_reg;
    assign m_box_left   = m_left_reg;
    assign m_box_top    = m_top_reg;
    assign m_box_width  = m_width_reg;
    assign m_box_height = m_height_reg;
    assign m_row_number = m_row_reg;

endmodule

FILE: sv/yolo_row_decode_filter_unit.sv
// Top level of the YOLO row decode and filter unit: config registers, front, queue, back.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_value, s_row_end
//   m_        out        m_valid / m_ready  class, confidence, box, row number
//   cfg_      in         cfg_we             cfg_addr, cfg_wdata
//
// The front takes one row value per cycle while the queue is not full. Each finished row
// of six or more values goes into the queue; the back takes each row through product,
// offset, scale multiply, clamp and write states, so rows of six or more values stream
// at one value per cycle while m_ready is high. Results are registered in the write state.
// Reset is synchronous and clears control state and loads config defaults.
// With m_ready low the result holds, the back finishes the next row and waits, the queue
// fills, and s_ready drops.
`timescale 1ns / 1ps

module yolo_row_decode_filter_unit
    import yrdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [16:0] s_value,
    input  logic        s_row_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_class_id,
    output logic [16:0] m_confidence,
    output logic [12:0] m_box_left,
    output logic [12:0] m_box_top,
    output logic [12:0] m_box_width,
    output logic [12:0] m_box_height,
    output logic [15:0] m_row_number,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    cfg_t     cfg_reg;
    row_rec_t push_rec, head_rec;
    logic     q_push, q_pop, q_full, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.conf_threshold <= 17'd32768;
            cfg_reg.net_width      <= 13'd416;
            cfg_reg.net_height     <= 13'd416;
            cfg_reg.pad_left       <= 12'd0;
            cfg_reg.pad_top        <= 12'd0;
            cfg_reg.inverse_scale  <= 24'd65536;
            cfg_reg.frame_width    <= 14'd640;
            cfg_reg.frame_height   <= 14'd480;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CONF_THRESHOLD: cfg_reg.conf_threshold <= cfg_wdata[16:0];
                REG_NET_WIDTH:      cfg_reg.net_width      <= cfg_wdata[12:0];
                REG_NET_HEIGHT:     cfg_reg.net_height     <= cfg_wdata[12:0];
                REG_PAD_LEFT:       cfg_reg.pad_left       <= cfg_wdata[11:0];
                REG_PAD_TOP:        cfg_reg.pad_top        <= cfg_wdata[11:0];
                REG_INVERSE_SCALE:  cfg_reg.inverse_scale  <= cfg_wdata[23:0];
                REG_FRAME_WIDTH:    cfg_reg.frame_width    <= cfg_wdata[13:0];
                REG_FRAME_HEIGHT:   cfg_reg.frame_height   <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    yrdf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_row_end  (s_row_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_push_rec (push_rec)
    );

    yrdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty)
    );

    yrdf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_head       (head_rec),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_class_id   (m_class_id),
        .m_confidence (m_confidence),
        .m_box_left   (m_box_left),
        .m_box_top    (m_box_top),
        .m_box_width  (m_box_width),
        .m_box_height (m_box_height),
        .m_row_number (m_row_number)
    );

endmodule
